@@ design/tah3d_pkg.sv @@
package tah3d_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 4;

  // Internal distances carry this many fraction bits beyond the coordinates.
  localparam int EXTRA_BITS = 8;

  localparam int AREA_W = 29;
  localparam int DIST_W = 17;

  typedef struct packed {
    logic [DIST_W-1:0] ab;
    logic [DIST_W-1:0] ac;
    logic [DIST_W-1:0] bc;
  } dist_t;

endpackage

@@ design/triangle_area_heron_3d_core.sv @@
// Triangle area from three 3D points by Heron's formula.
// Input channel: in_valid/in_stall with nine signed coordinates (a, b, c points),
// each carrying FRAC_BITS fraction bits. A beat is taken when in_valid is high
// and in_stall low. Output channel: out_valid/out_stall with the area and the
// three side lengths, unsigned with FRAC_BITS fraction bits, floored.
// The block is a single pipeline that takes one beat every cycle while no
// result is held with out_stall high. D_W = COORD_WIDTH + 10 is the number of
// stages of the distance square root and A_W that of the area square root.
// The two bit-serial square-root pipelines set the depth; the widest step is
// the 2F x 2F product split into four partial products over two stages.
// Reset clears the valid bits of every stage; payload registers are not reset.
// When a result waits with out_stall high the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
module triangle_area_heron_3d_core #(
  parameter int COORD_WIDTH = tah3d_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = tah3d_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       in_a_x,
  input  logic signed [COORD_WIDTH-1:0]       in_a_y,
  input  logic signed [COORD_WIDTH-1:0]       in_a_z,
  input  logic signed [COORD_WIDTH-1:0]       in_b_x,
  input  logic signed [COORD_WIDTH-1:0]       in_b_y,
  input  logic signed [COORD_WIDTH-1:0]       in_b_z,
  input  logic signed [COORD_WIDTH-1:0]       in_c_x,
  input  logic signed [COORD_WIDTH-1:0]       in_c_y,
  input  logic signed [COORD_WIDTH-1:0]       in_c_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tah3d_pkg::AREA_W-1:0]        out_tri_area,
  output logic [tah3d_pkg::DIST_W-1:0]        out_dist_ab,
  output logic [tah3d_pkg::DIST_W-1:0]        out_dist_ac,
  output logic [tah3d_pkg::DIST_W-1:0]        out_dist_bc
);

  import tah3d_pkg::*;

  localparam int DIF_W  = COORD_WIDTH + 1;
  localparam int SQ_W   = 2 * COORD_WIDTH + 1;
  localparam int SUM_W  = 2 * COORD_WIDTH + 3;
  localparam int D_W    = (SUM_W + 2 * EXTRA_BITS + 1) / 2;
  localparam int F_W    = D_W + 2;
  localparam int Q_W    = 4 * F_W;
  localparam int SH     = 2 * FRAC_BITS + 36;
  localparam int QS_W   = Q_W - SH;
  localparam int AR_W   = QS_W + (QS_W % 2);
  localparam int A_W    = AR_W / 2;

  logic en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: coordinate differences, in the order ab, ac, bc and x, y, z.
  logic                    v1_r;
  logic signed [DIF_W-1:0] dif_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dif_r[0] <= DIF_W'(in_a_x) - DIF_W'(in_b_x);
      dif_r[1] <= DIF_W'(in_a_y) - DIF_W'(in_b_y);
      dif_r[2] <= DIF_W'(in_a_z) - DIF_W'(in_b_z);
      dif_r[3] <= DIF_W'(in_a_x) - DIF_W'(in_c_x);
      dif_r[4] <= DIF_W'(in_a_y) - DIF_W'(in_c_y);
      dif_r[5] <= DIF_W'(in_a_z) - DIF_W'(in_c_z);
      dif_r[6] <= DIF_W'(in_b_x) - DIF_W'(in_c_x);
      dif_r[7] <= DIF_W'(in_b_y) - DIF_W'(in_c_y);
      dif_r[8] <= DIF_W'(in_b_z) - DIF_W'(in_c_z);
    end
  end

  // Stage 2: squares.
  logic              v2_r;
  logic [SQ_W-1:0]   sq_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_sq
    logic signed [2*DIF_W-1:0] prod;
    assign prod = dif_r[i] * dif_r[i];
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[i] <= prod[SQ_W-1:0];
      end
    end
  end

  // Stage 3: squared distances, scaled up for the extra fraction bits.
  logic                                 v3_r;
  logic [SUM_W-1:0]                     sum_r [3];
  logic [2:0][2*D_W-1:0]                drad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sum
    always_ff @(posedge clk) begin
      if (en) begin
        sum_r[k] <= SUM_W'(sq_r[3*k]) + SUM_W'(sq_r[3*k+1]) + SUM_W'(sq_r[3*k+2]);
      end
    end
    assign drad[k] = (2*D_W)'({sum_r[k], (2*EXTRA_BITS)'(0)});
  end

  logic                  vd;
  logic [2:0][D_W-1:0]   droot;

  tah3d_isqrt_pipe #(
    .ROOT_W (D_W),
    .LANES  (3)
  ) u_dist_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_rad    (drad),
    .out_valid (vd),
    .out_root  (droot)
  );

  // Output distances: drop the extra fraction bits and fit the field width.
  dist_t dist_d;
  logic [DIST_W+D_W-1:0] dext [3];

  for (genvar k = 0; k < 3; k++) begin : g_dext
    assign dext[k] = (DIST_W+D_W)'(droot[k] >> EXTRA_BITS);
  end

  assign dist_d.ab = dext[0][DIST_W-1:0];
  assign dist_d.ac = dext[1][DIST_W-1:0];
  assign dist_d.bc = dext[2][DIST_W-1:0];

  // Stage 4: perimeter (twice the half-perimeter).
  logic                v4_r;
  logic [F_W-1:0]      per4_r;
  logic [D_W-1:0]      d4_r [3];
  dist_t               dist4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      per4_r  <= F_W'(droot[0]) + F_W'(droot[1]) + F_W'(droot[2]);
      d4_r[0] <= droot[0];
      d4_r[1] <= droot[1];
      d4_r[2] <= droot[2];
      dist4_r <= dist_d;
    end
  end

  // Stage 5: Heron factors P - 2D, signed.
  logic                   v5_r;
  logic [F_W-1:0]         per5_r;
  logic signed [F_W:0]    fac_r [3];
  dist_t                  dist5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_fac
    always_ff @(posedge clk) begin
      if (en) begin
        fac_r[k] <= $signed({1'b0, per4_r}) - $signed((F_W+1)'({d4_r[k], 1'b0}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      per5_r  <= per4_r;
      dist5_r <= dist4_r;
    end
  end

  // Stage 6: two first products; a negative factor clamps the area to zero.
  logic                 v6_r;
  logic                 neg6_r;
  logic [2*F_W-1:0]     m1_r;
  logic [2*F_W-1:0]     m2_r;
  dist_t                dist6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg6_r  <= fac_r[0][F_W] | fac_r[1][F_W] | fac_r[2][F_W];
      m1_r    <= (2*F_W)'(per5_r) * (2*F_W)'(fac_r[0][F_W-1:0]);
      m2_r    <= (2*F_W)'(fac_r[1][F_W-1:0]) * (2*F_W)'(fac_r[2][F_W-1:0]);
      dist6_r <= dist5_r;
    end
  end

  // Stage 7: partial products of the final multiplication.
  logic                 v7_r;
  logic                 neg7_r;
  logic [2*F_W-1:0]     pp_ll_r;
  logic [2*F_W-1:0]     pp_lh_r;
  logic [2*F_W-1:0]     pp_hl_r;
  logic [2*F_W-1:0]     pp_hh_r;
  dist_t                dist7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg7_r  <= neg6_r;
      pp_ll_r <= (2*F_W)'(m1_r[F_W-1:0])     * (2*F_W)'(m2_r[F_W-1:0]);
      pp_lh_r <= (2*F_W)'(m1_r[F_W-1:0])     * (2*F_W)'(m2_r[2*F_W-1:F_W]);
      pp_hl_r <= (2*F_W)'(m1_r[2*F_W-1:F_W]) * (2*F_W)'(m2_r[F_W-1:0]);
      pp_hh_r <= (2*F_W)'(m1_r[2*F_W-1:F_W]) * (2*F_W)'(m2_r[2*F_W-1:F_W]);
      dist7_r <= dist6_r;
    end
  end

  // Stage 8: full radicand, scaled down and clamped.
  logic [Q_W-1:0]   q_sum;
  logic             v8_r;
  logic [AR_W-1:0]  arad_r;
  dist_t            dist8_r;

  assign q_sum = (Q_W'(pp_hh_r) << (2*F_W)) + (Q_W'(pp_hl_r) << F_W)
               + (Q_W'(pp_lh_r) << F_W) + Q_W'(pp_ll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arad_r  <= neg7_r ? '0 : AR_W'(q_sum[Q_W-1:SH]);
      dist8_r <= dist7_r;
    end
  end

  logic                 va;
  logic [0:0][A_W-1:0]  aroot;

  tah3d_isqrt_pipe #(
    .ROOT_W (A_W),
    .LANES  (1)
  ) u_area_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v8_r),
    .in_rad    (arad_r),
    .out_valid (va),
    .out_root  (aroot)
  );

  // Distances travel beside the area root.
  dist_t dist_dl_r [A_W];

  always_ff @(posedge clk) begin
    if (en) begin
      dist_dl_r[0] <= dist8_r;
    end
  end

  for (genvar s = 1; s < A_W; s++) begin : g_dl
    always_ff @(posedge clk) begin
      if (en) begin
        dist_dl_r[s] <= dist_dl_r[s-1];
      end
    end
  end

  logic [AREA_W+A_W-1:0] aext;

  assign aext         = (AREA_W+A_W)'(aroot[0]);
  assign out_valid    = va;
  assign out_tri_area = aext[AREA_W-1:0];
  assign out_dist_ab  = dist_dl_r[A_W-1].ab;
  assign out_dist_ac  = dist_dl_r[A_W-1].ac;
  assign out_dist_bc  = dist_dl_r[A_W-1].bc;

endmodule

@@ design/tah3d_isqrt_pipe.sv @@
module tah3d_isqrt_pipe #(
  parameter int ROOT_W = 26,
  parameter int LANES  = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [LANES-1:0][2*ROOT_W-1:0]      in_rad,
  output logic                                out_valid,
  output logic [LANES-1:0][ROOT_W-1:0]        out_root
);

  // Restoring square root, one result bit per stage, most significant first.
  logic [ROOT_W+1:0]   rem_r  [ROOT_W][LANES];
  logic [ROOT_W-1:0]   root_r [ROOT_W][LANES];
  logic [2*ROOT_W-1:0] rad_r  [ROOT_W][LANES];
  logic [ROOT_W-1:0]   vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ROOT_W-2:0], in_valid};
    end
  end

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [ROOT_W+1:0]   rem_i;
      logic [ROOT_W-1:0]   root_i;
      logic [2*ROOT_W-1:0] rad_i;
      logic [ROOT_W+3:0]   cur;
      logic [ROOT_W+3:0]   trial;
      logic [ROOT_W+3:0]   diff;
      logic                ge;

      if (s == 0) begin : g_first
        assign rem_i  = '0;
        assign root_i = '0;
        assign rad_i  = in_rad[l];
      end else begin : g_next
        assign rem_i  = rem_r[s-1][l];
        assign root_i = root_r[s-1][l];
        assign rad_i  = rad_r[s-1][l];
      end

      assign cur   = {rem_i, rad_i[2*ROOT_W-1 -: 2]};
      assign trial = (ROOT_W+4)'({root_i, 2'b01});
      assign diff  = cur - trial;
      assign ge    = (cur >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s][l]  <= ge ? diff[ROOT_W+1:0] : cur[ROOT_W+1:0];
          root_r[s][l] <= {root_i[ROOT_W-2:0], ge};
          rad_r[s][l]  <= rad_i << 2;
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_root[l] = root_r[ROOT_W-1][l];
  end

  assign out_valid = vld_r[ROOT_W-1];

endmodule

@@ design/tah3d_checker.sv @@
module tah3d_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tah3d_pkg::AREA_W-1:0]  out_tri_area,
  input logic [tah3d_pkg::DIST_W-1:0]  out_dist_ab,
  input logic [tah3d_pkg::DIST_W-1:0]  out_dist_ac
);

  // The input side only waits while a finished beat is held at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_tri_area)))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  // Two sides shorter than one output step leave no room for any area.
  a_tiny_area: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dist_ab == '0 && out_dist_ac == '0) |-> (out_tri_area == '0))
    else $error("non-zero area with two vanishing sides");

endmodule

bind triangle_area_heron_3d_core tah3d_checker u_tah3d_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_tri_area (out_tri_area),
  .out_dist_ab  (out_dist_ab),
  .out_dist_ac  (out_dist_ac)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import tah3d_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int LATENCY = 68;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1880;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic [AREA_W-1:0] area;
    logic [DIST_W-1:0] ab;
    logic [DIST_W-1:0] ac;
    logic [DIST_W-1:0] bc;
  } tri_result_t;

  typedef struct {
    coord_t      pt[9];
    bit          typed;
    tri_result_t res;
  } tri_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  coord_t pts[9];
  logic out_valid;
  logic out_stall;
  logic [AREA_W-1:0] out_tri_area;
  logic [DIST_W-1:0] out_dist_ab;
  logic [DIST_W-1:0] out_dist_ac;
  logic [DIST_W-1:0] out_dist_bc;

  tri_result_t pending_tris[$];
  tri_row_t    directed_rows[$];
  int          errors;
  bit          stim_done;
  bit          stall_quiet;

  triangle_area_heron_3d_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(pts[0]), .in_a_y(pts[1]), .in_a_z(pts[2]),
    .in_b_x(pts[3]), .in_b_y(pts[4]), .in_b_z(pts[5]),
    .in_c_x(pts[6]), .in_c_y(pts[7]), .in_c_z(pts[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tri_area(out_tri_area), .out_dist_ab(out_dist_ab),
    .out_dist_ac(out_dist_ac), .out_dist_bc(out_dist_bc)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] floor_root(logic [127:0] v);
    logic [63:0]  r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'b0, r | (64'd1 << b)};
      if (c * c <= v) r = c[63:0];
    end
    return r;
  endfunction

  // Side length with eight extra fraction bits, from the exact squared distance.
  function automatic logic [63:0] fine_side(coord_t p[9], int i, int j);
    logic signed [63:0] d;
    logic [63:0] sq;
    sq = '0;
    for (int k = 0; k < 3; k++) begin
      d = 64'(p[i + k]) - 64'(p[j + k]);
      sq += d * d;
    end
    return floor_root({64'b0, sq} << (2 * EXTRA_BITS));
  endfunction

  function automatic tri_result_t heron_area(coord_t p[9]);
    tri_result_t r;
    logic [63:0] dab, dac, dbc, per;
    logic signed [63:0] f0, f1, f2;
    logic [127:0] q;
    dab = fine_side(p, 0, 3);
    dac = fine_side(p, 0, 6);
    dbc = fine_side(p, 3, 6);
    per = dab + dac + dbc;
    f0 = $signed(per) - 2 * $signed(dab);
    f1 = $signed(per) - 2 * $signed(dac);
    f2 = $signed(per) - 2 * $signed(dbc);
    r.area = '0;
    if (f0 >= 0 && f1 >= 0 && f2 >= 0) begin
      q = 128'(per) * 128'(f0) * 128'(f1) * 128'(f2);
      r.area = AREA_W'(floor_root(q >> (2 * FRAC_BITS_DEF + 36)));
    end
    r.ab = DIST_W'(dab >> EXTRA_BITS);
    r.ac = DIST_W'(dac >> EXTRA_BITS);
    r.bc = DIST_W'(dbc >> EXTRA_BITS);
    return r;
  endfunction

  function automatic int short_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic add_row(input int v[9], input bit typed,
                         input int ar, input int ab, input int ac, input int bc);
    tri_row_t row;
    foreach (v[k]) row.pt[k] = coord_t'(v[k]);
    row.typed = typed;
    row.res.area = AREA_W'(ar);
    row.res.ab = DIST_W'(ab);
    row.res.ac = DIST_W'(ac);
    row.res.bc = DIST_W'(bc);
    directed_rows.push_back(row);
  endtask

  task automatic send_beat(input coord_t p[9], input bit typed, input tri_result_t res);
    int  gap;
    bit  taken;
    gap = short_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    foreach (p[k]) pts[k] <= p[k];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    pending_tris.push_back(typed ? res : heron_area(p));
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 127) - 64);
      2: return $urandom_range(0, 1) ? coord_t'(-32768) : coord_t'(32767);
      default: return coord_t'($urandom_range(0, 4095) - 2048);
    endcase
  endfunction

  initial begin
    coord_t      p[9];
    tri_result_t dummy;
    int          mode, kk;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    foreach (pts[k]) pts[k] = '0;
    errors = 0;
    stim_done = 1'b0;
    stall_quiet = 1'b0;
    dummy = '{default: '0};

    // Zero, coincident points, axis extremes, full-range and a few small triangles.
    add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0, 0);
    add_row('{100, -7, 3, 100, -7, 3, 100, -7, 3}, 1, 0, 0, 0, 0);
    add_row('{-32768, 0, 0, 32767, 0, 0, -32768, 0, 0}, 1, 0, 65535, 0, 65535);
    add_row('{0, -32768, 0, 0, 32767, 0, 0, -32768, 0}, 1, 0, 65535, 0, 65535);
    add_row('{0, 0, -32768, 0, 0, 32767, 0, 0, -32768}, 1, 0, 65535, 0, 65535);
    add_row('{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768},
            0, 0, 0, 0, 0);
    add_row('{-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 32767},
            0, 0, 0, 0, 0);
    add_row('{32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0}, 0, 0, 0, 0, 0);
    add_row('{-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768},
            0, 0, 0, 0, 0);
    add_row('{0, 0, 0, 16, 0, 0, 0, 16, 0}, 0, 0, 0, 0, 0);
    add_row('{0, 0, 0, 1, 0, 0, 0, 1, 0}, 0, 0, 0, 0, 0);
    add_row('{0, 0, 0, 1, 1, 1, 2, 2, 2}, 0, 0, 0, 0, 0);
    add_row('{0, 0, 0, 3, 5, 7, 6, 10, 14}, 0, 0, 0, 0, 0);
    add_row('{-5, 9, 2, 1000, -3000, 20, 999, -2999, 21}, 0, 0, 0, 0, 0);
    add_row('{-1, -1, -1, 1, 1, 1, -1, 1, -1}, 0, 0, 0, 0, 0);
    add_row('{0, 0, 0, 0, 0, 0, 1, 0, 0}, 0, 0, 0, 0, 0);
    add_row('{-32768, 0, 0, 32767, 0, 0, 0, 32767, 0}, 0, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) send_beat(directed_rows[r].pt, directed_rows[r].typed,
                                         directed_rows[r].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (pending_tris.size() != 0) @(posedge clk);
      end
      if (n % 300 == 0) stall_quiet = !stall_quiet;
      mode = $urandom_range(0, 3);
      foreach (p[k]) p[k] = rand_coord(mode);
      case ($urandom_range(0, 9))
        0: for (int k = 0; k < 3; k++) p[6 + k] = p[k];
        1: begin
          // Collinear points: C continues the line from A through B.
          kk = $urandom_range(0, 3);
          for (int k = 0; k < 3; k++) begin
            p[k] = rand_coord(1);
            p[3 + k] = p[k] + coord_t'($urandom_range(0, 200) - 100);
            p[6 + k] = p[k] + coord_t'(kk) * (p[3 + k] - p[k]);
          end
        end
        default: ;
      endcase
      send_beat(p, 1'b0, dummy);
    end
    in_valid <= 1'b0;
    while (pending_tris.size() != 0) @(posedge clk);
    repeat (LATENCY + 32) @(posedge clk);
    stim_done = 1'b1;
  end

  // Result side back-pressure: runs of stall, with quiet stretches.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!stall_quiet && $urandom_range(0, 5) == 0)
          stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    tri_result_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_tris.size() == 0) begin
          $display("%0t: result beat with nothing expected, area %0d", $time, out_tri_area);
          errors++;
        end else begin
          want = pending_tris.pop_front();
          if (out_tri_area !== want.area) begin
            $display("%0t: tri_area expected %0d got %0d", $time, want.area, out_tri_area);
            errors++;
          end
          if (out_dist_ab !== want.ab) begin
            $display("%0t: dist_ab expected %0d got %0d", $time, want.ab, out_dist_ab);
            errors++;
          end
          if (out_dist_ac !== want.ac) begin
            $display("%0t: dist_ac expected %0d got %0d", $time, want.ac, out_dist_ac);
            errors++;
          end
          if (out_dist_bc !== want.bc) begin
            $display("%0t: dist_bc expected %0d got %0d", $time, want.bc, out_dist_bc);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (!stim_done && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (stim_done && errors == 0 && pending_tris.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (!stim_done) $display("%0t: run timed out", $time);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
